/* rtl/core/frm_pkg.sv */
// frm_pkg: shared widths and constants of the frame rate meter
// no dependencies
package frm_pkg;

    localparam int STAMP_W = 32;
    localparam int TIME_W  = 16;
    localparam int RATE_W  = 22;
    localparam int SCALE_W = 18;

    // rate scale 1000 ms/s times 256 fraction steps
    localparam logic [SCALE_W-1:0] RATE_SCALE   = 18'd256000;
    // 60 frames per second with 8 fraction bits
    localparam logic [RATE_W-1:0]  DEFAULT_RATE = 22'd15360;
    localparam logic [RATE_W-1:0]  RATE_MAX     = 22'h3FFFFF;
    localparam logic [TIME_W-1:0]  TIME_MAX     = 16'hFFFF;

    // frame time handed from the front to the queue
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] frame_time;
    } t_time_push;

endpackage

/* rtl/core/frm_front.sv */
// frm_front: accepts timestamps and forms the saturated frame time
// depends on frm_pkg
module frm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_queue_full,
    input  logic [frm_pkg::STAMP_W-1:0]  i_stamp_ms,
    output frm_pkg::t_time_push          o_push
);
    import frm_pkg::*;

    logic [STAMP_W-1:0] r_last_stamp;
    logic               r_stamp_seen;
    logic [STAMP_W-1:0] diff;
    logic [TIME_W-1:0]  frame_time;
    logic               accept;

    assign accept = i_push && !i_queue_full;
    assign diff   = i_stamp_ms - r_last_stamp;

    always_comb begin
        if (!r_stamp_seen) begin
            frame_time = '0;
        end else if (diff[STAMP_W-1:TIME_W] != '0) begin
            frame_time = TIME_MAX;
        end else begin
            frame_time = diff[TIME_W-1:0];
        end
    end

    assign o_push.valid      = accept;
    assign o_push.frame_time = frame_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
            r_stamp_seen <= 1'b0;
        end else if (accept) begin
            r_last_stamp <= i_stamp_ms;
            r_stamp_seen <= 1'b1;
        end
    end

endmodule

/* rtl/core/frm_queue.sv */
// frm_queue: two-entry queue of frame times between front and back
// depends on frm_pkg
module frm_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frm_pkg::t_time_push         i_push,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_valid,
    output logic [frm_pkg::TIME_W-1:0]  o_frame_time
);
    import frm_pkg::*;

    logic [TIME_W-1:0] r_slots [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              do_pop;

    assign o_full       = (r_count == 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_frame_time = r_slots[r_rd_ptr];
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slots[r_wr_ptr] <= i_push.frame_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !i_push.valid) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/frm_back.sv */
// frm_back: frame time ring, running sum and iterative rate divider
// depends on frm_pkg
module frm_back #(
    parameter int WINDOW = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  logic [frm_pkg::TIME_W-1:0]  i_q_frame_time,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [frm_pkg::TIME_W-1:0]  o_frame_time_ms,
    output logic [frm_pkg::RATE_W-1:0]  o_frame_rate_q8
);
    import frm_pkg::*;

    localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SW   = TIME_W + $clog2(WINDOW + 1);
    localparam int DW   = SCALE_W + CW;
    localparam int XW   = (DW > RATE_W) ? DW : RATE_W;
    localparam int STW  = $clog2(DW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [TIME_W-1:0] r_ring [WINDOW];
    logic [TIME_W-1:0] r_rd_data;

    logic [2:0]        r_state;
    logic [IW-1:0]     r_slot;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_sum;
    logic [TIME_W-1:0] r_delta;
    logic [SW-1:0]     r_rem;
    logic [DW-1:0]     r_quo;
    logic [STW-1:0]    r_step;

    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_time;
    logic [RATE_W-1:0] r_out_rate;

    logic              ring_full;
    logic [TIME_W-1:0] old_time;
    logic [SW-1:0]     n_sum;
    logic [CW-1:0]     n_count;
    logic [IW-1:0]     n_slot;
    logic [SW:0]       rem_sh;
    logic              sub_ok;
    logic [XW-1:0]     quo_x;
    logic              out_free;

    assign ring_full = (r_count == CW'(WINDOW));
    assign old_time  = ring_full ? r_rd_data : '0;
    assign n_sum     = r_sum - SW'(old_time) + SW'(r_delta);
    assign n_count   = ring_full ? r_count : r_count + CW'(1);
    assign n_slot    = (r_slot == IW'(WINDOW - 1)) ? '0 : r_slot + IW'(1);

    // one restoring step per cycle
    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign sub_ok = (rem_sh >= {1'b0, r_sum});
    assign quo_x  = XW'(r_quo);

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // ring memory, registered read at the current slot
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_ring[r_slot];
        if (r_state == S_UPD) begin
            r_ring[r_slot] <= r_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_slot  <= n_slot;
                    r_state <= (n_sum == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (r_step == STW'(DW - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_delta <= i_q_frame_time;
            end
            S_UPD: begin
                r_rem  <= '0;
                r_quo  <= DW'(RATE_SCALE) * DW'(n_count);
                r_step <= '0;
            end
            S_DIV: begin
                r_step <= r_step + STW'(1);
                if (sub_ok) begin
                    r_rem <= SW'(rem_sh - {1'b0, r_sum});
                end else begin
                    r_rem <= rem_sh[SW-1:0];
                end
                r_quo <= {r_quo[DW-2:0], sub_ok};
            end
            default: begin
                // quotient held until the result register takes it
            end
        endcase
    end

    // result holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_time <= r_delta;
            if (r_sum == '0) begin
                r_out_rate <= DEFAULT_RATE;
            end else begin
                r_out_rate <= (quo_x > XW'(RATE_MAX)) ? RATE_MAX : quo_x[RATE_W-1:0];
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_frame_time_ms = r_out_time;
    assign o_frame_rate_q8 = r_out_rate;

endmodule

/* rtl/core/frame_rate_meter_top.sv */
// frame_rate_meter_top: top level of the moving-average frame rate meter
// depends on frm_pkg, frm_front, frm_queue, frm_back
//
// each pushed transaction is a millisecond timestamp taken at the end of a
// frame; each popped transaction returns that frame's time (difference to the
// previous stamp, saturated to 16 bits, zero for the first stamp after reset)
// and the rate over the last WINDOW frames, floor(256000 * count / sum) in
// frames per second with 8 fraction bits, 15360 (60 fps) while the sum is 0;
// each frame passes the back end states idle, update, divide (skipped for a
// zero sum) and done, divide running the restoring divider that retires
// one quotient bit per cycle; the front end and a two-deep frame time queue
// keep taking stamps while the divider runs, and a finished result waits in
// its own register so the next frame can start before it is popped
module frame_rate_meter_top #(
    parameter int WINDOW = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input side: stamp transactions
    input  logic                        push,
    output logic                        full,
    input  logic [frm_pkg::STAMP_W-1:0] i_stamp_ms,
    // result side: frame time and rate transactions
    output logic                        empty,
    input  logic                        pop,
    output logic [frm_pkg::TIME_W-1:0]  o_frame_time_ms,
    output logic [frm_pkg::RATE_W-1:0]  o_frame_rate_q8
);
    import frm_pkg::*;

    t_time_push        front_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [TIME_W-1:0] q_frame_time;

    // front: timestamp difference and saturation
    frm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_queue_full (q_full),
        .i_stamp_ms   (i_stamp_ms),
        .o_push       (front_push)
    );

    // short queue so front and back stall on their own
    frm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_valid      (q_valid),
        .o_frame_time (q_frame_time)
    );

    // back: ring, running sum, divider and result register
    frm_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_frame_time  (q_frame_time),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_frame_time_ms (o_frame_time_ms),
        .o_frame_rate_q8 (o_frame_rate_q8)
    );

    assign full = q_full;

endmodule

/* tb/sv/tb_frame_rate_meter_top.sv */
`timescale 1ns / 1ps
// tb_frame_rate_meter_top: self-checking bench for the frame rate meter, with a bit-exact
// predictor of frame time and averaged rate, corner and random stamp streams, random gaps
// depends on frm_pkg and frame_rate_meter_top
module tb_frame_rate_meter_top;
    import frm_pkg::*;

    localparam int WINDOW = 10;
    // hang guard limit in ns, this leaves a wide margin over the worst run
    localparam int RUN_LIMIT_NS = 2_000_000;
    // drain time after the last result, above the back end latency
    localparam int TAIL_CYCLES = 60;

    // one popped transaction as the bench expects it
    typedef struct packed {
        logic [TIME_W-1:0] frame_time;
        logic [RATE_W-1:0] rate_q8;
    } t_frame_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [STAMP_W-1:0]  i_stamp_ms = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [TIME_W-1:0]   o_frame_time_ms;
    logic [RATE_W-1:0]   o_frame_rate_q8;

    // predictor state, mirrors the averaging window of the block
    logic [STAMP_W-1:0]  prev_stamp = '0;
    logic                has_prev = 1'b0;
    logic [TIME_W-1:0]   time_hist [WINDOW] = '{default: '0};
    int                  hist_slot = 0;
    int                  hist_fill = 0;
    logic [31:0]         hist_sum = '0;

    // results still owed by the block, oldest first
    t_frame_result       pending_frames [$];
    int                  fail_count = 0;
    // percent chance per cycle of a push gap and of a pop stall
    int                  push_idle_pct = 0;
    int                  pop_stall_pct = 0;
    // running stamp of the random streams
    logic [STAMP_W-1:0]  next_stamp = '0;

    frame_rate_meter_top #(
        .WINDOW(WINDOW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_stamp_ms     (i_stamp_ms),
        .empty          (empty),
        .pop            (pop),
        .o_frame_time_ms(o_frame_time_ms),
        .o_frame_rate_q8(o_frame_rate_q8)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // frame time and window rate for one accepted stamp; advances the window
    function automatic t_frame_result predict_frame(input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] diff;
        logic [63:0]        quot;
        t_frame_result      res;
        // first stamp after reset has no predecessor, its frame time is zero
        diff = has_prev ? stamp - prev_stamp : '0;
        // backward stamps wrap to a huge difference and saturate here too
        if (diff > STAMP_W'(TIME_MAX))
            diff = STAMP_W'(TIME_MAX);
        prev_stamp = stamp;
        has_prev   = 1'b1;
        // replace the oldest entry and keep the sum in step
        hist_sum = hist_sum - 32'(time_hist[hist_slot]) + diff;
        time_hist[hist_slot] = diff[TIME_W-1:0];
        hist_slot = (hist_slot + 1 >= WINDOW) ? 0 : hist_slot + 1;
        if (hist_fill < WINDOW)
            hist_fill++;
        res.frame_time = diff[TIME_W-1:0];
        if (hist_sum == 0) begin
            // all filled frame times zero: report 60 fps
            res.rate_q8 = DEFAULT_RATE;
        end else begin
            quot = (64'(RATE_SCALE) * 64'(hist_fill)) / 64'(hist_sum);
            if (quot > 64'(RATE_MAX))
                quot = 64'(RATE_MAX);
            res.rate_q8 = quot[RATE_W-1:0];
        end
        return res;
    endfunction

    // one stamp transaction, with random gaps ahead of it; push stays high after
    // acceptance so back to back transactions never toggle it within one step
    task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            push <= 1'b0;
            i_stamp_ms <= $urandom;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_stamp_ms <= stamp;
        do
            @(posedge i_clk);
        while (full);
        pending_frames.push_back(predict_frame(stamp));
    endtask

    // sender holds off until every owed result has been popped
    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_frames.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly frame-like steps with random content, some near saturation,
    // some repeated stamps, some jumps to arbitrary stamps and some going back
    task automatic run_stamp_stream(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                next_stamp += $urandom_range(1, 60);
            else if (pick < 80)
                next_stamp += $urandom_range(0, 3);
            else if (pick < 88)
                next_stamp += $urandom_range(65000, 66000);
            else if (pick < 94)
                next_stamp = $urandom;
            else
                next_stamp -= $urandom_range(1, 100);
            send_stamp(next_stamp);
        end
    endtask

    // first stamp, wrap across 2^32, backward stamp, exact and over saturation,
    // a window of zeros back to the zero-sum rate, then the largest rate
    task automatic test_corner_stamps();
        logic [STAMP_W-1:0] corner_stamps [19] = '{
            32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0004,
            32'h0001_0003, 32'h0002_0003, 32'h0002_0004,
            32'h0002_0004, 32'h0002_0004, 32'h0002_0004, 32'h0002_0004,
            32'h0002_0004, 32'h0002_0004, 32'h0002_0004, 32'h0002_0004,
            32'h0002_0004, 32'h0002_0004, 32'h0002_0005, 32'h0000_0000
        };
        push_idle_pct = 0;
        pop_stall_pct = 0;
        foreach (corner_stamps[k])
            send_stamp(corner_stamps[k]);
        next_stamp = 32'h0000_0000;
        wait_for_results();
    endtask

    // back to back transactions on both sides
    task automatic test_steady_stream();
        push_idle_pct = 0;
        pop_stall_pct = 0;
        run_stamp_stream(133);
        wait_for_results();
    endtask

    // sparse pushes against an always ready receiver
    task automatic test_sender_gaps();
        push_idle_pct = 74;
        pop_stall_pct = 0;
        run_stamp_stream(133);
        wait_for_results();
    endtask

    // heavy pop stalls so results back up and full is exercised
    task automatic test_receiver_stalls();
        push_idle_pct = 0;
        pop_stall_pct = 74;
        run_stamp_stream(133);
        wait_for_results();
    endtask

    // moderate gaps on both sides
    task automatic test_mixed_gaps();
        push_idle_pct = 34;
        pop_stall_pct = 34;
        run_stamp_stream(133);
        wait_for_results();
    endtask

    // result side: check each popped transaction, then pick the next pop level
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected result: frame_time_ms %0d frame_rate_q8 %0d",
                       o_frame_time_ms, o_frame_rate_q8);
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                if (o_frame_time_ms !== want.frame_time) begin
                    $error("frame_time_ms expected %0d actual %0d",
                           want.frame_time, o_frame_time_ms);
                    fail_count++;
                end
                if (o_frame_rate_q8 !== want.rate_q8) begin
                    $error("frame_rate_q8 expected %0d actual %0d",
                           want.rate_q8, o_frame_rate_q8);
                    fail_count++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_stamps();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_gaps();
        // let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_frames.size() != 0) begin
            $error("%0d results never arrived", pending_frames.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/frm_pkg.sv
rtl/core/frm_front.sv
rtl/core/frm_queue.sv
rtl/core/frm_back.sv
rtl/core/frame_rate_meter_top.sv
tb/sv/tb_frame_rate_meter_top.sv
